// ===== rtl/egbd_pkg.sv =====
`default_nettype none

package egbd_pkg;

	localparam int MAX_PREFIX = 31;
	localparam int ZC_W       = 6;
	localparam int CODE_W     = 32;
	localparam int VALUE_W    = 33;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       mode;
	} in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      overflow;
	} out_t;

	// finished number waiting for the value mapping
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              mode;
		logic              overflow;
	} res_t;

	function automatic out_t map_code(input res_t r);
		out_t                      o;
		logic signed [VALUE_W-1:0] half;
		half = $signed({2'b00, r.code[CODE_W-1:1]});
		if (r.overflow) begin
			o.value = '0;
		end else if (!r.mode) begin
			o.value = $signed({1'b0, r.code}) - VALUE_W'(1);
		end else if (r.code[0]) begin
			o.value = half;
		end else begin
			o.value = -half;
		end
		o.overflow = r.overflow;
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/egbd_front.sv =====
`default_nettype none

module egbd_front import egbd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_data,
	output logic      head_valid,
	output in_t       head_data,
	input  wire logic pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	in_t           fifo_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;

	assign in_stall   = (cnt_q == CW'(DEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (cnt_q != '0);
	assign head_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/egbd_back.sv =====
`default_nettype none

module egbd_back import egbd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire in_t  head_data,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);

	// decoder state
	logic              rp_q;
	logic [ZC_W-1:0]   zc_q;
	logic [ZC_W-1:0]   bl_q;
	logic [CODE_W-1:0] acc_q;

	logic              s1_valid_q;
	res_t              res_s1;
	logic              out_valid_q;
	out_t              out_q;

	logic              rp;
	logic [ZC_W-1:0]   zc;
	logic [ZC_W-1:0]   bl;
	logic [CODE_W-1:0] acc;
	logic              done;
	logic              ovf;
	logic              out_free;
	logic              s1_free;
	res_t              res_next;

	assign out_free  = !out_valid_q || !out_stall;
	assign s1_free   = !s1_valid_q || out_free;
	assign pop       = head_valid && s1_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// walk the byte LSB first; the first finished number ends the byte
	always_comb begin
		rp   = rp_q;
		zc   = zc_q;
		bl   = bl_q;
		acc  = acc_q;
		done = 1'b0;
		ovf  = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!done) begin
				if (!rp) begin
					if (!head_data.data_byte[i]) begin
						zc = zc + ZC_W'(1);
						if (zc > ZC_W'(MAX_PREFIX)) begin
							done = 1'b1;
							ovf  = 1'b1;
						end
					end else if (zc == '0) begin
						done = 1'b1;
						acc  = CODE_W'(1);
					end else begin
						rp  = 1'b1;
						bl  = zc;
						acc = CODE_W'(1);
					end
				end else begin
					acc = {acc[CODE_W-2:0], head_data.data_byte[i]};
					bl  = bl - ZC_W'(1);
					if (bl == '0) begin
						done = 1'b1;
					end
				end
			end
		end
		res_next.code     = ovf ? '0 : acc;
		res_next.mode     = head_data.mode;
		res_next.overflow = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= 1'b0;
			zc_q  <= '0;
			bl_q  <= '0;
			acc_q <= '0;
		end else if (pop) begin
			if (done) begin
				rp_q  <= 1'b0;
				zc_q  <= '0;
				bl_q  <= '0;
				acc_q <= '0;
			end else begin
				rp_q  <= rp;
				zc_q  <= zc;
				bl_q  <= bl;
				acc_q <= acc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= pop && done;
			end
			if (out_free) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && pop && done) begin
			res_s1 <= res_next;
		end
		if (out_free && s1_valid_q) begin
			out_q <= map_code(res_s1);
		end
	end

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.overflow |-> out_q.value == '0)
		else $error("overflow result carries a nonzero value");

	a_idle_state: assert property (@(posedge clk) disable iff (!arst_n)
		!rp_q |-> (bl_q == '0) && (acc_q == '0))
		else $error("prefix phase with payload state left over");

	a_payload_state: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q |-> (bl_q != '0) && (bl_q <= zc_q) && (zc_q <= ZC_W'(MAX_PREFIX)))
		else $error("payload counter out of range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_free |=> s1_valid_q && $stable(res_s1))
		else $error("held result lost while output stalled");

endmodule

`default_nettype wire

// ===== rtl/elias_gamma_byte_aligned_decoder.sv =====
// Elias gamma decoder, byte aligned, one byte per transfer.
// Throughput: one byte per cycle unless out_stall backs up into in_stall; each byte is
// resolved by the 8-bit unrolled decode step. A byte that ends a number passes the
// queue, the decode register and the mapping register before its result is on out_valid.
// Reset (arst_n low, async): queue emptied, no result pending, decoder back to counting
// prefix zeros.
`default_nettype none

module elias_gamma_byte_aligned_decoder import egbd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);

	logic head_valid;
	in_t  head_data;
	logic pop;

	egbd_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop)
	);

	egbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== verif/egbd_checker.sv =====
`timescale 1ns / 100ps

module egbd_checker import egbd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_stall,
	input  wire in_t  in_data,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire out_t out_data,
	output int        mismatches,
	output int        waiting
);

	logic        in_payload;
	logic [5:0]  zeros_seen;
	logic [5:0]  payload_left;
	logic [31:0] code_bits;
	out_t        expected_numbers[$];
	out_t        want;
	int          fail_total;

	function automatic logic signed [32:0] code_to_value(input logic [31:0] code,
			input logic signed_map);
		logic signed [32:0] half;
		half = $signed({2'b00, code[31:1]});
		if (!signed_map) begin
			return $signed({1'b0, code}) - 33'sd1;
		end
		// odd codes map to non-negative values, even codes to negative
		return code[0] ? half : 33'sd0 - half;
	endfunction

	task automatic clear_decoder();
		in_payload   = 1'b0;
		zeros_seen   = '0;
		payload_left = '0;
		code_bits    = '0;
	endtask

	task automatic queue_result(input out_t r);
		expected_numbers = {expected_numbers, r};
	endtask

	task automatic decode_byte(input in_t item);
		out_t r;
		for (int i = 0; i < 8; i++) begin
			if (!in_payload) begin
				if (!item.data_byte[i]) begin
					zeros_seen = zeros_seen + 6'd1;
					if (zeros_seen > MAX_PREFIX) begin
						clear_decoder();
						r.value    = '0;
						r.overflow = 1'b1;
						queue_result(r);
						return;
					end
				end else if (zeros_seen == 0) begin
					clear_decoder();
					r.value    = code_to_value(32'd1, item.mode);
					r.overflow = 1'b0;
					queue_result(r);
					return;
				end else begin
					in_payload   = 1'b1;
					payload_left = zeros_seen;
					code_bits    = 32'd1;
				end
			end else begin
				code_bits    = {code_bits[30:0], item.data_byte[i]};
				payload_left = payload_left - 6'd1;
				if (payload_left == 0) begin
					r.value    = code_to_value(code_bits, item.mode);
					r.overflow = 1'b0;
					clear_decoder();
					// rest of the byte is dropped
					queue_result(r);
					return;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decoder();
			expected_numbers.delete();
			fail_total = 0;
			mismatches <= 0;
			waiting    <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_numbers.size() == 0) begin
					$display("%0t: unexpected result value %0d overflow %0b", $time,
						out_data.value, out_data.overflow);
					fail_total++;
				end else begin
					want = expected_numbers.pop_front();
					if (out_data.value !== want.value) begin
						$display("%0t: value expected %0d actual %0d", $time,
							want.value, out_data.value);
						fail_total++;
					end
					if (out_data.overflow !== want.overflow) begin
						$display("%0t: overflow expected %0b actual %0b", $time,
							want.overflow, out_data.overflow);
						fail_total++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(in_data);
			end
			waiting    <= expected_numbers.size();
			mismatches <= fail_total;
		end
	end

endmodule

// ===== verif/tb_elias_gamma_byte_aligned_decoder.sv =====
`timescale 1ns / 100ps

module tb_elias_gamma_byte_aligned_decoder import egbd_pkg::*;;

	localparam int RANDOM_BYTES = 1900;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_stall;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	int          mismatches;
	int          waiting;
	int          cycle_count = 0;
	int unsigned burst_left  = 0;
	int unsigned bytes_sent  = 0;
	logic        hold_req    = 1'b0;

	elias_gamma_byte_aligned_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	egbd_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one byte transfer; bursts of back-to-back bytes separated by random gaps
	task automatic put_byte(input in_t item);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		burst_left--;
		bytes_sent++;
	endtask

	// n prefix zeros, a one, then n payload bits MSB first; tail of last byte is random
	task automatic send_number(input int unsigned n, input logic [31:0] payload,
			input logic sign_mode);
		logic [63:0] stream;
		int unsigned len;
		in_t         item;
		stream = {$urandom, $urandom};
		len    = 2 * n + 1;
		for (int k = 0; k < n; k++) begin
			stream[k]         = 1'b0;
			stream[n + 1 + k] = payload[n - 1 - k];
		end
		stream[n] = 1'b1;
		for (int b = 0; b * 8 < len; b++) begin
			item.data_byte = stream[b * 8 +: 8];
			item.mode      = ((b + 1) * 8 >= len) ? sign_mode : 1'($urandom);
			put_byte(item);
		end
	endtask

	// 32 zeros in a row trip the prefix limit on the last bit of the fourth byte
	task automatic send_overflow();
		in_t item;
		for (int b = 0; b < 4; b++) begin
			item.data_byte = 8'h00;
			item.mode      = 1'($urandom);
			put_byte(item);
		end
	endtask

	initial begin : receiver
		int unsigned phase_len;
		int unsigned stall_pct;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			phase_len = $urandom_range(20, 200);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 30;
				2: stall_pct = 70;
				default: stall_pct = 95;
			endcase
			for (int c = 0; c < phase_len; c++) begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned target;
		int unsigned n;
		int unsigned pick;
		in_t         item;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero-length prefix, both mappings
		send_number(0, 32'h0, 1'b0);
		send_number(0, 32'h0, 1'b1);
		// longest codes: all ones unsigned, largest negative signed
		send_number(31, 32'h7FFF_FFFF, 1'b0);
		send_number(31, 32'h7FFF_FFFE, 1'b1);
		send_overflow();
		// single bit number, upper bits dropped
		item.data_byte = 8'hFF;
		item.mode      = 1'b1;
		put_byte(item);
		send_number(1, 32'h0, 1'b1);
		send_number(2, 32'h3, 1'b1);

		hold_req = 1'b1;
		target   = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
				send_number(n, $urandom, 1'($urandom));
			end else if (pick < 78) begin
				send_overflow();
			end else begin
				// noise: arbitrary bytes, often breaking a number apart
				item.data_byte = 8'($urandom);
				item.mode      = 1'($urandom);
				put_byte(item);
			end
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (waiting != 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== elias_gamma_byte_aligned_decoder.f =====
rtl/egbd_pkg.sv
rtl/egbd_front.sv
rtl/egbd_back.sv
rtl/elias_gamma_byte_aligned_decoder.sv
verif/egbd_checker.sv
verif/tb_elias_gamma_byte_aligned_decoder.sv
